FILE: sv/heap_sort_engine_unit_assert.svh
// Assertion macros used by the heap sort engine datapath.
`ifndef HEAP_SORT_ENGINE_UNIT_ASSERT_SVH
`define HEAP_SORT_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Invariant checked at every clock edge outside reset.
`define HSE_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Same-cycle implication.
`define HSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define HSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HSE_ASSERT(lbl, expr, msg)
`define HSE_ASSERT_IMP(lbl, ante, cons, msg)
`define HSE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/hse_pkg.sv
// Types, step codes and the microprogram of the heap sort engine.
package hse_pkg;

    // Width of the key field on both stream interfaces.
    localparam int TDATA_W = 32;

    // Microprogram step addresses.
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_LOAD        = 4'd0;
    localparam step_t STEP_BUILD_INIT  = 4'd1;
    localparam step_t STEP_BUILD_TEST  = 4'd2;
    localparam step_t STEP_BUILD_SETUP = 4'd3;
    localparam step_t STEP_BUILD_VAL   = 4'd4;
    localparam step_t STEP_SIFT_RD     = 4'd5;
    localparam step_t STEP_SIFT_CMP    = 4'd6;
    localparam step_t STEP_SORT_INIT   = 4'd7;
    localparam step_t STEP_SORT_TEST   = 4'd8;
    localparam step_t STEP_SORT_RD     = 4'd9;
    localparam step_t STEP_SORT_SWAP   = 4'd10;
    localparam step_t STEP_OUT_INIT    = 4'd11;
    localparam step_t STEP_OUT_RD      = 4'd12;
    localparam step_t STEP_OUT_LOAD    = 4'd13;
    localparam step_t STEP_CLEAR       = 4'd14;

    // Datapath action of one step.
    typedef enum logic [3:0] {
        DP_IDLE        = 4'd0,
        DP_LOAD        = 4'd1,
        DP_BUILD_INIT  = 4'd2,
        DP_BUILD_SETUP = 4'd3,
        DP_BUILD_VAL   = 4'd4,
        DP_SIFT_RD     = 4'd5,
        DP_SIFT_CMP    = 4'd6,
        DP_SORT_INIT   = 4'd7,
        DP_SORT_RD     = 4'd8,
        DP_SORT_SWAP   = 4'd9,
        DP_OUT_INIT    = 4'd10,
        DP_OUT_RD      = 4'd11,
        DP_OUT_LOAD    = 4'd12,
        DP_CLEAR       = 4'd13
    } dp_op_t;

    // Sequencing of the step counter.
    typedef enum logic [2:0] {
        SEQ_NEXT   = 3'd0,  // step + 1
        SEQ_JUMP   = 3'd1,  // target
        SEQ_BRANCH = 3'd2,  // target if condition, else step + 1
        SEQ_HOLD   = 3'd3,  // target if condition, else stay
        SEQ_RET_IF = 3'd4   // return address if condition, else target
    } seq_op_t;

    // Condition selected for a branch.
    typedef enum logic [2:0] {
        COND_NONE      = 3'd0,
        COND_LAST_IN   = 3'd1,
        COND_I_ZERO    = 3'd2,
        COND_I_LT2     = 3'd3,
        COND_SIFT_DONE = 3'd4,
        COND_OUT_FREE  = 3'd5,
        COND_K_MORE    = 3'd6
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        dp_op_t  dp;
        seq_op_t seq;
        cond_t   cond;
        step_t   target;
        logic    link;    // store step + 1 as return address
    } ctrl_word_t;

    // Status flags from the datapath for conditional jumps.
    typedef struct packed {
        logic last_in;
        logic i_zero;
        logic i_lt2;
        logic sift_done;
        logic out_free;
        logic k_more;
    } dp_status_t;

    // Microprogram read-only table.
    function automatic ctrl_word_t ucode(input step_t step);
        ctrl_word_t cw;
        cw = '{dp: DP_CLEAR, seq: SEQ_JUMP, cond: COND_NONE, target: STEP_LOAD, link: 1'b0};
        unique case (step)
            STEP_LOAD:
                cw = '{DP_LOAD, SEQ_HOLD, COND_LAST_IN, STEP_BUILD_INIT, 1'b0};
            STEP_BUILD_INIT:
                cw = '{DP_BUILD_INIT, SEQ_NEXT, COND_NONE, STEP_LOAD, 1'b1};
            STEP_BUILD_TEST:
                cw = '{DP_IDLE, SEQ_BRANCH, COND_I_ZERO, STEP_SORT_INIT, 1'b0};
            STEP_BUILD_SETUP:
                cw = '{DP_BUILD_SETUP, SEQ_NEXT, COND_NONE, STEP_LOAD, 1'b0};
            STEP_BUILD_VAL:
                cw = '{DP_BUILD_VAL, SEQ_JUMP, COND_NONE, STEP_SIFT_RD, 1'b0};
            STEP_SIFT_RD:
                cw = '{DP_SIFT_RD, SEQ_NEXT, COND_NONE, STEP_LOAD, 1'b0};
            STEP_SIFT_CMP:
                cw = '{DP_SIFT_CMP, SEQ_RET_IF, COND_SIFT_DONE, STEP_SIFT_RD, 1'b0};
            STEP_SORT_INIT:
                cw = '{DP_SORT_INIT, SEQ_NEXT, COND_NONE, STEP_LOAD, 1'b1};
            STEP_SORT_TEST:
                cw = '{DP_IDLE, SEQ_BRANCH, COND_I_LT2, STEP_OUT_INIT, 1'b0};
            STEP_SORT_RD:
                cw = '{DP_SORT_RD, SEQ_NEXT, COND_NONE, STEP_LOAD, 1'b0};
            STEP_SORT_SWAP:
                cw = '{DP_SORT_SWAP, SEQ_JUMP, COND_NONE, STEP_SIFT_RD, 1'b0};
            STEP_OUT_INIT:
                cw = '{DP_OUT_INIT, SEQ_NEXT, COND_NONE, STEP_LOAD, 1'b0};
            STEP_OUT_RD:
                cw = '{DP_OUT_RD, SEQ_HOLD, COND_OUT_FREE, STEP_OUT_LOAD, 1'b0};
            STEP_OUT_LOAD:
                cw = '{DP_OUT_LOAD, SEQ_BRANCH, COND_K_MORE, STEP_OUT_RD, 1'b0};
            STEP_CLEAR:
                cw = '{DP_CLEAR, SEQ_JUMP, COND_NONE, STEP_LOAD, 1'b0};
            default:
                cw = '{DP_CLEAR, SEQ_JUMP, COND_NONE, STEP_LOAD, 1'b0};
        endcase
        return cw;
    endfunction

endpackage

FILE: sv/hse_sequencer.sv
// Step counter, program table lookup and jump logic of the heap sort engine.
module hse_sequencer
    import hse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output ctrl_word_t cw
);

    step_t step_reg;
    step_t step_next;
    step_t ret_reg;
    step_t ret_next;
    step_t step_inc;
    logic  cond_true;

    // Control word of the current step.
    assign cw       = ucode(step_reg);
    assign step_inc = step_reg + step_t'(1);

    // Condition selection.
    always_comb
    begin
        unique case (cw.cond)
            COND_NONE:      cond_true = 1'b0;
            COND_LAST_IN:   cond_true = status.last_in;
            COND_I_ZERO:    cond_true = status.i_zero;
            COND_I_LT2:     cond_true = status.i_lt2;
            COND_SIFT_DONE: cond_true = status.sift_done;
            COND_OUT_FREE:  cond_true = status.out_free;
            COND_K_MORE:    cond_true = status.k_more;
            default:        cond_true = 1'b0;
        endcase
    end

    // Next step and return address.
    always_comb
    begin
        ret_next = cw.link ? step_inc : ret_reg;
        unique case (cw.seq)
            SEQ_NEXT:   step_next = step_inc;
            SEQ_JUMP:   step_next = cw.target;
            SEQ_BRANCH: step_next = cond_true ? cw.target : step_inc;
            SEQ_HOLD:   step_next = cond_true ? cw.target : step_reg;
            SEQ_RET_IF: step_next = cond_true ? ret_reg : cw.target;
            default:    step_next = STEP_CLEAR;
        endcase
    end

    // Step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_LOAD;
            ret_reg  <= STEP_BUILD_TEST;
        end
        else
        begin
            step_reg <= step_next;
            ret_reg  <= ret_next;
        end
    end

endmodule

FILE: sv/hse_datapath.sv
// Key store, counters, sift-down compare and output register of the heap sort engine.
module hse_datapath
    import hse_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_word_t         cw,
    output dp_status_t         status,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tlast,
    output logic               m_axis_tuser
);

`include "heap_sort_engine_unit_assert.svh"

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = IW + 2;

    typedef logic [KEY_WIDTH-1:0] key_t;

    // Key store with two registered read ports and one write port.
    key_t          key_mem [DEPTH];
    key_t          rd_a_reg;
    key_t          rd_b_reg;
    logic [IW-1:0] rd_a_addr;
    logic [IW-1:0] rd_b_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    key_t          wr_data;

    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic [CW-1:0] heap_reg, heap_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] k_reg, k_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [PW-1:0] lc_reg, lc_next;
    logic [PW-1:0] rc_reg, rc_next;
    logic          lc_ok_reg, lc_ok_next;
    logic          rc_ok_reg, rc_ok_next;
    key_t          val_reg, val_next;
    logic                out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0]  out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;
    logic                out_user_reg, out_user_next;

    logic          accept;
    logic          store_full;
    logic [CW-1:0] i_dec;
    logic [CW-1:0] k_inc;
    logic [PW-1:0] lc_pos;
    logic [PW-1:0] rc_pos;
    logic [PW-1:0] heap_ext;
    logic          a_gt;
    logic          take_b;
    logic          sift_done;
    logic          out_free;

    // Handshake and shared arithmetic.
    assign s_axis_tready = (cw.dp == DP_LOAD);
    assign accept        = s_axis_tready && s_axis_tvalid;
    assign store_full    = (count_reg == CW'(DEPTH));
    assign i_dec         = i_reg - CW'(1);
    assign k_inc         = k_reg + CW'(1);
    assign lc_pos        = PW'({pos_reg, 1'b1});
    assign rc_pos        = lc_pos + PW'(1);
    assign heap_ext      = PW'(heap_reg);
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Pick the larger child against the element being sifted.
    assign a_gt      = lc_ok_reg && (rd_a_reg > val_reg);
    assign take_b    = rc_ok_reg && (a_gt ? (rd_b_reg > rd_a_reg) : (rd_b_reg > val_reg));
    assign sift_done = !a_gt && !take_b;

    // Status flags for the sequencer.
    assign status.last_in   = s_axis_tvalid && s_axis_tlast;
    assign status.i_zero    = (i_reg == '0);
    assign status.i_lt2     = (i_reg < CW'(2));
    assign status.sift_done = sift_done;
    assign status.out_free  = out_free;
    assign status.k_more    = (k_inc != count_reg);

    // Datapath action decoder.
    always_comb
    begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        heap_next      = heap_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        lc_next        = lc_reg;
        rc_next        = rc_reg;
        lc_ok_next     = lc_ok_reg;
        rc_ok_next     = rc_ok_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        rd_a_addr      = '0;
        rd_b_addr      = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_a_reg;
        unique case (cw.dp)
            DP_IDLE:
            begin
            end
            DP_LOAD:
            begin
                if (accept)
                begin
                    if (store_full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[IW-1:0];
                        wr_data    = KEY_WIDTH'(s_axis_tdata);
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            DP_BUILD_INIT:
            begin
                heap_next = count_reg;
                i_next    = count_reg >> 1;
            end
            DP_BUILD_SETUP:
            begin
                rd_a_addr = i_dec[IW-1:0];
                pos_next  = i_dec[IW-1:0];
                i_next    = i_dec;
            end
            DP_BUILD_VAL:
            begin
                val_next = rd_a_reg;
            end
            DP_SIFT_RD:
            begin
                rd_a_addr  = lc_pos[IW-1:0];
                rd_b_addr  = rc_pos[IW-1:0];
                lc_next    = lc_pos;
                rc_next    = rc_pos;
                lc_ok_next = (lc_pos < heap_ext);
                rc_ok_next = (rc_pos < heap_ext);
            end
            DP_SIFT_CMP:
            begin
                // Move the larger child up into the hole, or drop the element in.
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                if (sift_done)
                begin
                    wr_data = val_reg;
                end
                else if (take_b)
                begin
                    wr_data  = rd_b_reg;
                    pos_next = rc_reg[IW-1:0];
                end
                else
                begin
                    wr_data  = rd_a_reg;
                    pos_next = lc_reg[IW-1:0];
                end
            end
            DP_SORT_INIT:
            begin
                i_next = count_reg;
            end
            DP_SORT_RD:
            begin
                rd_a_addr = '0;
                rd_b_addr = i_dec[IW-1:0];
            end
            DP_SORT_SWAP:
            begin
                // Root goes to the end; the last heap entry is sifted from the root.
                wr_en     = 1'b1;
                wr_addr   = i_dec[IW-1:0];
                wr_data   = rd_a_reg;
                val_next  = rd_b_reg;
                heap_next = i_dec;
                i_next    = i_dec;
                pos_next  = '0;
            end
            DP_OUT_INIT:
            begin
                k_next = '0;
            end
            DP_OUT_RD:
            begin
                rd_a_addr = k_reg[IW-1:0];
            end
            DP_OUT_LOAD:
            begin
                out_valid_next = 1'b1;
                out_data_next  = TDATA_W'(rd_a_reg);
                out_last_next  = (k_inc == count_reg);
                out_user_next  = dropped_reg;
                k_next         = k_inc;
            end
            DP_CLEAR:
            begin
                count_next   = '0;
                dropped_next = 1'b0;
                heap_next    = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Key store access.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= key_mem[rd_a_addr];
        rd_b_reg <= key_mem[rd_b_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            heap_reg      <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            pos_reg       <= '0;
            lc_ok_reg     <= 1'b0;
            rc_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            heap_reg      <= heap_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            pos_reg       <= pos_next;
            lc_ok_reg     <= lc_ok_next;
            rc_ok_reg     <= rc_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        lc_reg       <= lc_next;
        rc_reg       <= rc_next;
        val_reg      <= val_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

    // The fill count never passes the store depth.
    `HSE_ASSERT(a_count_range, count_reg <= CW'(DEPTH), "key count beyond store depth")
    // A result is only loaded into a free output register.
    `HSE_ASSERT_IMP(a_out_free, cw.dp == DP_OUT_LOAD, !out_valid_reg, "output register overwritten")
    // The hole being sifted always lies inside the heap.
    `HSE_ASSERT_IMP(a_sift_in_heap, cw.dp == DP_SIFT_CMP, CW'(pos_reg) < heap_reg,
        "sift position outside heap")
    // Loading continues after a request that is not last.
    `HSE_ASSERT_NXT(a_load_stays, accept && !s_axis_tlast, s_axis_tready,
        "loading left on a request that is not last")

endmodule

FILE: sv/heap_sort_engine_unit.sv
// Top level of the heap sort engine: sequencer and datapath.
//
// Keys arrive on the slave stream, one request per cycle, and are stored until
// the request marked last; keys beyond DEPTH are dropped and flag the set. The
// set is then sorted in place by heap sort under a microprogram, and leaves in
// ascending order on the master stream with tlast on the final key and tuser as
// the overflow flag. The input is not ready while a set is sorted or emitted.
// The sort is bound by the key store, which has two read ports and one write port:
// a sift-down is set up by a test, a read and a load of the element to sift, then
// reads both children and writes the hole once per level it descends plus a final
// time. Building runs about n/2 such sifts and the extraction n-1; emitting reads
// each key and loads it into the output register once that register is free. The
// key store needs no clearing pass after reset.
module heap_sort_engine_unit
    import hse_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [31:0] key
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [31:0] sorted_key
    output logic               m_axis_tlast,
    output logic               m_axis_tuser    // [0] overflow
);

    ctrl_word_t cw;
    dp_status_t status;

    // Microprogram sequencer.
    hse_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cw     (cw)
    );

    // Key store and datapath.
    hse_datapath #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cw            (cw),
        .status        (status),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
